>>> rtl/core/b2a_pkg.sv
package b2a_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = 6;
    localparam int IDX_W      = 4;

    localparam logic [CNT_W-1:0] NBITS_8  = CNT_W'(8);
    localparam logic [CNT_W-1:0] NBITS_16 = CNT_W'(16);
    localparam logic [CNT_W-1:0] NBITS_32 = CNT_W'(32);

    // index of the most significant digit for each width
    localparam logic [IDX_W-1:0] TOP_IDX_HEX8  = IDX_W'(1);
    localparam logic [IDX_W-1:0] TOP_IDX_DEC8  = IDX_W'(2);
    localparam logic [IDX_W-1:0] TOP_IDX_DEC16 = IDX_W'(4);
    localparam logic [IDX_W-1:0] TOP_IDX_DEC32 = IDX_W'(NUM_DIGITS - 1);

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_A     = 8'h41;
    localparam logic [7:0] ASCII_PLUS  = 8'h2B;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        CMD_HEX8   = 3'd0,
        CMD_DEC8   = 3'd1,
        CMD_DEC16  = 3'd2,
        CMD_UDEC32 = 3'd3,
        CMD_SDEC32 = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] value;   // msb-aligned, first bit to shift in at the top
        logic [CNT_W-1:0]   nbits;
    } conv_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } conv_stat_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib <= 4'd9)
        begin
            ch = ASCII_ZERO + {4'b0000, nib};
        end
        else
        begin
            ch = ASCII_A + {4'b0000, nib - 4'd10};
        end
        return ch;
    endfunction

endpackage

>>> rtl/core/b2a_dabble.sv
// bit-serial shift-add-3 binary to bcd
module b2a_dabble (
    input  logic                         clk,
    input  logic                         rst_n,
    input  b2a_pkg::conv_req_t           req,
    output b2a_pkg::conv_stat_t          stat,
    output logic [b2a_pkg::BCD_W-1:0]    bcd
);

    logic [b2a_pkg::VALUE_W-1:0] shift_reg, shift_next;
    logic [b2a_pkg::BCD_W-1:0]   bcd_reg, bcd_next;
    logic [b2a_pkg::BCD_W-1:0]   adj;
    logic [b2a_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < b2a_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            shift_next = req.value;
            bcd_next   = '0;
            cnt_next   = req.nbits;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[b2a_pkg::VALUE_W-2:0], 1'b0};
            bcd_next   = {adj[b2a_pkg::BCD_W-2:0], shift_reg[b2a_pkg::VALUE_W-1]};
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == b2a_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign bcd       = bcd_reg;

endmodule

>>> rtl/core/binary_to_ascii_digits_unit.sv
// hex8 skips the converter and goes straight to its chars; decimal formats (nbits = 8, 16
//   or 32) first pass through the shift-add-3 converter, one bit per cycle
// one char per cycle once converted, while out_ready stays high; a request holds the block
//   until its final char is loaded, set by the serial converter and the single char port
// the next request is taken while the final char still waits in the output register
// reset: rst_n asynchronous, active low; clears control state, no output pending
module binary_to_ascii_digits_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [31:0] value_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  ascii_char,
    output logic        is_last
);

    b2a_pkg::state_t state_reg, state_next;

    logic                       in_fire;
    logic                       is_dec;
    logic                       load_ok;
    logic                       positive;
    logic [31:0]                mag;

    b2a_pkg::conv_req_t         conv_req;
    b2a_pkg::conv_stat_t        conv_stat;
    logic [b2a_pkg::BCD_W-1:0]  bcd;

    // per-request control
    logic                       hex_mode_reg, hex_mode_next;
    logic                       sign_pend_reg, sign_pend_next;
    logic                       sign_neg_reg, sign_neg_next;
    logic [b2a_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [7:0]                 hex_reg, hex_next;
    logic [3:0]                 nib;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 out_char_reg, out_char_next;
    logic                       out_last_reg, out_last_next;

    assign in_ready = (state_reg == b2a_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    // the output register can take a new char when empty or being drained
    assign load_ok  = !out_valid_reg || out_ready;

    // signed zero takes '-' like any non-positive value
    assign positive = (value_bits != 32'd0) && !value_bits[31];
    assign mag      = positive ? value_bits : 32'd0 - value_bits;

    // decimal formats go through the converter; hex and undefined codes skip it
    always_comb
    begin
        is_dec         = 1'b0;
        conv_req.value = '0;
        conv_req.nbits = b2a_pkg::NBITS_32;
        unique case (cmd)
            b2a_pkg::CMD_DEC8:
            begin
                is_dec         = 1'b1;
                conv_req.value = {value_bits[7:0], 24'd0};
                conv_req.nbits = b2a_pkg::NBITS_8;
            end
            b2a_pkg::CMD_DEC16:
            begin
                is_dec         = 1'b1;
                conv_req.value = {value_bits[15:0], 16'd0};
                conv_req.nbits = b2a_pkg::NBITS_16;
            end
            b2a_pkg::CMD_UDEC32:
            begin
                is_dec         = 1'b1;
                conv_req.value = value_bits;
            end
            b2a_pkg::CMD_SDEC32:
            begin
                is_dec         = 1'b1;
                conv_req.value = mag;
            end
            default:
            begin
                is_dec = 1'b0;
            end
        endcase
        conv_req.start = in_fire && is_dec;
    end

    b2a_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (conv_req),
        .stat  (conv_stat),
        .bcd   (bcd)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            b2a_pkg::ST_IDLE:
            begin
                if (in_fire && is_dec)
                begin
                    state_next = b2a_pkg::ST_CONV;
                end
                else if (in_fire && (cmd == b2a_pkg::CMD_HEX8))
                begin
                    state_next = b2a_pkg::ST_EMIT;
                end
            end
            b2a_pkg::ST_CONV:
            begin
                if (conv_stat.done)
                begin
                    state_next = b2a_pkg::ST_EMIT;
                end
            end
            b2a_pkg::ST_EMIT:
            begin
                if (load_ok && !sign_pend_reg && (idx_reg == '0))
                begin
                    state_next = b2a_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = b2a_pkg::ST_IDLE;
            end
        endcase
    end

    // digit currently selected for output
    always_comb
    begin
        if (hex_mode_reg)
        begin
            nib = idx_reg[0] ? hex_reg[7:4] : hex_reg[3:0];
        end
        else
        begin
            nib = bcd[{idx_reg, 2'b00} +: 4];
        end
    end

    // datapath and outputs
    always_comb
    begin
        hex_mode_next  = hex_mode_reg;
        sign_pend_next = sign_pend_reg;
        sign_neg_next  = sign_neg_reg;
        idx_next       = idx_reg;
        hex_next       = hex_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            b2a_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    hex_mode_next  = (cmd == b2a_pkg::CMD_HEX8);
                    sign_pend_next = (cmd == b2a_pkg::CMD_SDEC32);
                    sign_neg_next  = !positive;
                    hex_next       = value_bits[7:0];
                    unique case (cmd)
                        b2a_pkg::CMD_HEX8:  idx_next = b2a_pkg::TOP_IDX_HEX8;
                        b2a_pkg::CMD_DEC8:  idx_next = b2a_pkg::TOP_IDX_DEC8;
                        b2a_pkg::CMD_DEC16: idx_next = b2a_pkg::TOP_IDX_DEC16;
                        default:            idx_next = b2a_pkg::TOP_IDX_DEC32;
                    endcase
                end
            end
            b2a_pkg::ST_CONV:
            begin
                idx_next = idx_reg;
            end
            b2a_pkg::ST_EMIT:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    if (sign_pend_reg)
                    begin
                        sign_pend_next = 1'b0;
                        out_char_next  = sign_neg_reg ? b2a_pkg::ASCII_MINUS
                                                      : b2a_pkg::ASCII_PLUS;
                        out_last_next  = 1'b0;
                    end
                    else
                    begin
                        out_char_next = hex_mode_reg ? b2a_pkg::hex_char(nib)
                                                     : b2a_pkg::ASCII_ZERO + {4'b0000, nib};
                        out_last_next = (idx_reg == '0);
                        idx_next      = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= b2a_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            sign_pend_reg <= 1'b0;
            hex_mode_reg  <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sign_pend_reg <= sign_pend_next;
            hex_mode_reg  <= hex_mode_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_neg_reg <= sign_neg_next;
        hex_reg      <= hex_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign ascii_char = out_char_reg;
    assign is_last    = out_last_reg;

    // converter finishes only while we wait for it
    a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        conv_stat.done |-> (state_reg == b2a_pkg::ST_CONV))
        else $error("converter done outside conversion state");

    // a new request never lands on a busy converter
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !conv_stat.busy)
        else $error("request accepted while converter busy");

    // digit index stays inside the bcd word
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == b2a_pkg::ST_EMIT) |-> (idx_reg < b2a_pkg::IDX_W'(b2a_pkg::NUM_DIGITS)))
        else $error("digit index out of range");

    // a sign char is never pending in hex mode
    a_sign_not_hex: assert property (@(posedge clk) disable iff (!rst_n)
        sign_pend_reg |-> !hex_mode_reg)
        else $error("sign pending in hex format");

endmodule

>>> tb/ascii_digit_checker.sv
`timescale 1ns / 100ps

module ascii_digit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [31:0] value_bits,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  ascii_char,
    input  logic        is_last,
    output int          error_count,
    output int          chars_pending,
    output int          requests_seen,
    output int          chars_checked
);

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } ascii_result_t;

    ascii_result_t expected_chars[$];

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'b0000, nib};
        if (nib < 4'd10)
        begin
            return b2a_pkg::ASCII_ZERO + wide;
        end
        return b2a_pkg::ASCII_A + (wide - 8'd10);
    endfunction

    // fixed number of decimal digits, leading zeros kept, last flag on the final one
    function automatic void push_decimal(input logic [31:0] v, input int count);
        logic [3:0]    digits [10];
        logic [31:0]   rest;
        ascii_result_t r;
        rest = v;
        for (int i = count - 1; i >= 0; i--)
        begin
            digits[i] = 4'(rest % 32'd10);
            rest      = rest / 32'd10;
        end
        for (int i = 0; i < count; i++)
        begin
            r.ch   = b2a_pkg::ASCII_ZERO + {4'b0000, digits[i]};
            r.last = (i == count - 1);
            expected_chars.push_back(r);
        end
    endfunction

    function automatic void predict_chars(input logic [2:0] c, input logic [31:0] v);
        ascii_result_t r;
        logic          positive;
        logic [31:0]   magnitude;
        case (c)
            b2a_pkg::CMD_HEX8:
            begin
                r.ch   = hex_digit(v[7:4]);
                r.last = 1'b0;
                expected_chars.push_back(r);
                r.ch   = hex_digit(v[3:0]);
                r.last = 1'b1;
                expected_chars.push_back(r);
            end
            b2a_pkg::CMD_DEC8:   push_decimal({24'd0, v[7:0]}, 3);
            b2a_pkg::CMD_DEC16:  push_decimal({16'd0, v[15:0]}, 5);
            b2a_pkg::CMD_UDEC32: push_decimal(v, 10);
            b2a_pkg::CMD_SDEC32:
            begin
                // zero takes the minus sign; the most negative value wraps to 2147483648
                positive  = (v != 32'd0) && !v[31];
                magnitude = positive ? v : (32'd0 - v);
                r.ch      = positive ? b2a_pkg::ASCII_PLUS : b2a_pkg::ASCII_MINUS;
                r.last    = 1'b0;
                expected_chars.push_back(r);
                push_decimal(magnitude, 10);
            end
            default:
            begin
                // undefined format: nothing comes out
            end
        endcase
    endfunction

    initial
    begin
        error_count   = 0;
        chars_pending = 0;
        requests_seen = 0;
        chars_checked = 0;
    end

    always @(posedge clk)
    begin
        ascii_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                chars_checked++;
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected character %h (is_last %b)", ascii_char, is_last);
                    error_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (ascii_char !== want.ch)
                    begin
                        $error("ascii_char mismatch: expected %h, actual %h", want.ch, ascii_char);
                        error_count++;
                    end
                    if (is_last !== want.last)
                    begin
                        $error("is_last mismatch: expected %b, actual %b", want.last, is_last);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                requests_seen++;
                predict_chars(cmd, value_bits);
            end
            chars_pending = expected_chars.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int IDLE_PCT         = 26;    // chance per cycle that a side idles
    localparam int RANDOM_REQUESTS  = 400;
    localparam int HOLD_AT          = 120;   // random request count that starts the hold-off
    localparam int SINK_HOLD_CYCLES = 240;   // long enough for the block to back up
    localparam int BURST_FIRST      = 250;   // window with no idling on either side
    localparam int BURST_LAST       = 330;
    localparam int DRAIN_CYCLES     = 60;    // covers one signed conversion plus its chars
    localparam int WATCHDOG_LIMIT   = 2000;

    // command codes the block does not define; it should swallow them
    localparam logic [2:0] CMD_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNDEF_MID   = 3'd6;
    localparam logic [2:0] CMD_UNDEF_LAST  = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  cmd;
    logic [31:0] value_bits;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  ascii_char;
    logic        is_last;

    int error_count;
    int chars_pending;
    int requests_seen;
    int chars_checked;
    int ignored_requests;

    bit no_idle;        // both sides stream back to back while set
    bit hold_request;   // asks the receiver for one long hold-off

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    binary_to_ascii_digits_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .value_bits (value_bits),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ascii_char (ascii_char),
        .is_last    (is_last)
    );

    ascii_digit_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .value_bits    (value_bits),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ascii_char    (ascii_char),
        .is_last       (is_last),
        .error_count   (error_count),
        .chars_pending (chars_pending),
        .requests_seen (requests_seen),
        .chars_checked (chars_checked)
    );

    // offer one request at a falling edge and hold it until the block takes it;
    // valid only drops when an idle cycle is chosen, never within the same step it rises
    task automatic send_request(input logic [2:0] c, input logic [31:0] v);
        while (!no_idle && ($urandom_range(99) < IDLE_PCT))
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        cmd        = c;
        value_bits = v;
        if (c > b2a_pkg::CMD_SDEC32)
        begin
            ignored_requests++;
        end
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        @(negedge clk);
    endtask

    // receiver: random backpressure, plus one long hold-off counted here
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready = 1'b0;
                repeat (SINK_HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                out_ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // watchdog: ends the run when neither channel moves for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        logic [2:0]  c;
        logic [31:0] v;
        logic [31:0] decade;
        int          defined_sent;
        bit          hold_started;

        rst_n            = 1'b0;
        in_valid         = 1'b0;
        cmd              = b2a_pkg::CMD_HEX8;
        value_bits       = 32'd0;
        no_idle          = 1'b0;
        hold_request     = 1'b0;
        hold_started     = 1'b0;
        ignored_requests = 0;
        defined_sent     = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, every format, upper bits that must be ignored
        send_request(b2a_pkg::CMD_HEX8,   32'h0000_0000);
        send_request(b2a_pkg::CMD_HEX8,   32'h0000_00FF);
        send_request(b2a_pkg::CMD_HEX8,   32'hFFFF_FF5A);
        send_request(b2a_pkg::CMD_HEX8,   32'h1234_56C9);
        send_request(b2a_pkg::CMD_DEC8,   32'h0000_0000);
        send_request(b2a_pkg::CMD_DEC8,   32'h0000_00FF);
        send_request(b2a_pkg::CMD_DEC8,   32'hABCD_EF09);
        send_request(b2a_pkg::CMD_DEC16,  32'h0000_0000);
        send_request(b2a_pkg::CMD_DEC16,  32'h0000_FFFF);
        send_request(b2a_pkg::CMD_DEC16,  32'hFFFF_2710);
        send_request(b2a_pkg::CMD_UDEC32, 32'h0000_0000);
        send_request(b2a_pkg::CMD_UDEC32, 32'hFFFF_FFFF);
        send_request(b2a_pkg::CMD_UDEC32, 32'd1000000000);
        send_request(b2a_pkg::CMD_UDEC32, 32'd999999999);
        // signed: zero keeps the minus sign, most negative value, both limits, -1 and +1
        send_request(b2a_pkg::CMD_SDEC32, 32'h0000_0000);
        send_request(b2a_pkg::CMD_SDEC32, 32'h8000_0000);
        send_request(b2a_pkg::CMD_SDEC32, 32'h7FFF_FFFF);
        send_request(b2a_pkg::CMD_SDEC32, 32'hFFFF_FFFF);
        send_request(b2a_pkg::CMD_SDEC32, 32'h0000_0001);
        // undefined formats should produce nothing at all
        send_request(CMD_UNDEF_FIRST, 32'hFFFF_FFFF);
        send_request(CMD_UNDEF_MID,   32'h0000_0000);
        send_request(CMD_UNDEF_LAST,  32'hA5A5_5A5A);
        send_request(b2a_pkg::CMD_HEX8,   32'h0000_00A0);

        // random part; ignored formats do not count toward the total
        while (defined_sent < RANDOM_REQUESTS)
        begin
            if ((defined_sent == HOLD_AT) && !hold_started)
            begin
                hold_request = 1'b1;
                hold_started = 1'b1;
            end
            no_idle = (defined_sent >= BURST_FIRST) && (defined_sent < BURST_LAST);

            if ($urandom_range(99) < 6)
            begin
                c = 3'($urandom_range(CMD_UNDEF_LAST, CMD_UNDEF_FIRST));
            end
            else
            begin
                c = 3'($urandom_range(b2a_pkg::CMD_SDEC32));
                defined_sent++;
            end

            case ($urandom_range(9))
                0, 1, 2, 3: v = $urandom;
                4:          v = 32'($urandom_range(99));
                5:          v = 32'd0 - 32'($urandom_range(1000, 1));
                6:
                begin
                    case ($urandom_range(3))
                        0:       v = 32'h0000_0000;
                        1:       v = 32'hFFFF_FFFF;
                        2:       v = 32'h8000_0000;
                        default: v = 32'h7FFF_FFFF;
                    endcase
                end
                7:
                begin
                    // around a power of ten, where digit carries happen
                    decade = 32'd1;
                    repeat ($urandom_range(9)) decade = decade * 32'd10;
                    v = decade + 32'($urandom_range(2)) - 32'd1;
                end
                default:
                begin
                    // 8/16-bit boundaries under random upper bits
                    v = $urandom;
                    case ($urandom_range(3))
                        0:       v[15:0] = 16'hFFFF;
                        1:       v[15:0] = 16'h0000;
                        2:       v[15:0] = 16'h00FF;
                        default: v[15:0] = 16'h0100;
                    endcase
                end
            endcase
            send_request(c, v);
        end
        in_valid = 1'b0;
        no_idle  = 1'b0;

        while (chars_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered hex8, dec8, dec16, udec32, signed dec32 and undefined commands:");
        $display("%0d requests (%0d ignored), %0d characters checked, one %0d-cycle hold-off",
                 requests_seen, ignored_requests, chars_checked, SINK_HOLD_CYCLES);
        if ((error_count == 0) && (chars_pending == 0))
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
